[rtl/core/csf_pkg.sv]
package csf_pkg;

  // Position width default (Q16.16 per axis)
  localparam int POS_WIDTH_DEF = 32;

  localparam int STEP_W     = 20;
  localparam int ROT_W      = 16;
  localparam int DATA_W     = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [STEP_W-1:0] MAX_STEP_RST  = 20'd6554;
  localparam logic [STEP_W-1:0] CRIT_STEP_RST = 20'd13107;
  localparam logic [ROT_W-1:0]  ROT_ONE       = 16'h4000;

  // Register index, taken from paddr[2]
  localparam logic REG_MAX_STEP  = 1'b0;
  localparam logic REG_CRIT_STEP = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQW,
    ST_ROOT,
    ST_SEL,
    ST_MUL,
    ST_MULW,
    ST_DIV,
    ST_UPD,
    ST_DONE
  } csf_state_t;

endpackage

[rtl/core/csf_if.sv]
interface csf_in_if import csf_pkg::*; #(
  parameter int POS_W = POS_WIDTH_DEF
) ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] target_x;
  logic [POS_W-1:0] target_y;
  logic [POS_W-1:0] target_z;
  logic [ROT_W-1:0] target_rot_w;
  logic [ROT_W-1:0] target_rot_x;
  logic [ROT_W-1:0] target_rot_y;
  logic [ROT_W-1:0] target_rot_z;

  modport source (
    output valid, target_x, target_y, target_z,
           target_rot_w, target_rot_x, target_rot_y, target_rot_z,
    input  ready
  );
  modport sink (
    input  valid, target_x, target_y, target_z,
           target_rot_w, target_rot_x, target_rot_y, target_rot_z,
    output ready
  );
endinterface

interface csf_out_if import csf_pkg::*; #(
  parameter int POS_W = POS_WIDTH_DEF
) ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic [POS_W-1:0] pos_z;
  logic [ROT_W-1:0] rot_w;
  logic [ROT_W-1:0] rot_x;
  logic [ROT_W-1:0] rot_y;
  logic [ROT_W-1:0] rot_z;
  logic             moved;

  modport source (
    output valid, pos_x, pos_y, pos_z, rot_w, rot_x, rot_y, rot_z, moved,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, rot_w, rot_x, rot_y, rot_z, moved,
    output ready
  );
endinterface

[rtl/core/clamped_step_position_follower.sv]
// Clamped step position follower.
// Input channel in_ch: one beat per frame, target position (x/y/z, signed
// Q16.16, POS_WIDTH bits) and target quaternion (w/x/y/z, signed Q1.14).
// Output channel out_ch: one beat per input beat, the follower pose after
// the frame plus a moved flag. APB port: reg 0 max_step at 0x0, reg 1
// critical_step at 0x4, 20-bit unsigned Q4.16, one wait-free access.
// One item at a time: in_ch.ready is high only while the sequencer idles.
// Per item: squares take 6 multiplier passes, the length takes POS_WIDTH+1
// square-root iterations, and a clamped step adds per axis 2 multiplier
// passes plus POS_WIDTH+1 divider iterations. in_ch.ready comes back in
// the same cycle as the result beat goes valid, so a new item is taken
// only once the previous one is through the sequencer.
// The result is held in an output register; a stalled receiver holds the
// sequencer in its final state until the previous beat drains.
// Reset: follower at origin, identity quaternion, thresholds to defaults.
module clamped_step_position_follower import csf_pkg::*; #(
  parameter int POS_WIDTH = POS_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  csf_in_if.sink                in_ch,
  csf_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  // magnitude of a difference needs one bit more than a position
  localparam int MAG_W  = POS_WIDTH + 1;
  localparam int LEN_W  = MAG_W;
  localparam int SUM_W  = 2 * MAG_W;
  localparam int HB_W   = (MAG_W + 1) / 2;
  localparam int SB_W   = (STEP_W + 2) / 2;
  localparam int B_W    = (HB_W > SB_W) ? HB_W : SB_W;
  localparam int NUM_W  = MAG_W + STEP_W + 2;
  localparam int ACC_W  = (SUM_W > NUM_W) ? SUM_W : NUM_W;
  localparam int DEN_W  = LEN_W + 1;
  localparam int CMP_W  = (LEN_W > STEP_W) ? LEN_W : STEP_W;

  // config
  logic [STEP_W-1:0] max_step;
  logic [STEP_W-1:0] crit_step;

  // sequencer
  csf_state_t state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic       ph_r, ph_nxt;

  // control strobes
  logic in_rdy;
  logic acc_init;
  logic acc_seed_len;
  logic mul_issue;
  logic sq_mode;
  logic sqrt_go;
  logic div_go;
  logic sel_go;
  logic upd_go;
  logic out_load;

  // item and follower state
  logic [POS_WIDTH-1:0] tgt_r  [3];
  logic [POS_WIDTH-1:0] fol_r  [3];
  logic [MAG_W-1:0]     mag_r  [3];
  logic [2:0]           neg_r;
  logic [ROT_W-1:0]     trot_r [4];
  logic [ROT_W-1:0]     quat_r [4];
  logic [STEP_W-1:0]    step_r;
  logic                 moved_r;

  // output register
  logic [POS_WIDTH-1:0] opos_r [3];
  logic [ROT_W-1:0]     orot_r [4];
  logic                 omoved_r;
  logic                 ovalid_r;

  // shared units
  logic [ACC_W-1:0]   acc;
  logic               mul_busy;
  logic [2*B_W-1:0]   mul_bop;
  logic [B_W-1:0]     mul_b;
  logic [LEN_W-1:0]   len;
  logic               sqrt_busy;
  logic [MAG_W-1:0]   quo;
  logic               div_busy;

  // datapath helpers
  logic [POS_WIDTH-1:0] in_tgt [3];
  logic [MAG_W-1:0]     in_diff [3];
  logic [CMP_W-1:0]     len_c, max_c, crit_c;
  logic                 len_zero, in_mid, over_crit;
  logic [MAG_W-1:0]     delta;

  csf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_step  (max_step),
    .crit_step (crit_step)
  );

  // Multiplier b operand: the magnitude itself for squares, 2*step for the
  // scaled move; fed half a word per beat.
  assign mul_bop = sq_mode ? (2*B_W)'(mag_r[axis_r]) : (2*B_W)'({step_r, 1'b0});
  assign mul_b   = ph_r ? mul_bop[2*B_W-1:B_W] : mul_bop[B_W-1:0];

  csf_mul #(
    .A_W   (MAG_W),
    .B_W   (B_W),
    .ACC_W (ACC_W)
  ) u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .init     (acc_init),
    .init_val (acc_seed_len ? ACC_W'(len) : '0),
    .issue    (mul_issue),
    .hi       (ph_r),
    .a        (mag_r[axis_r]),
    .b        (mul_b),
    .busy     (mul_busy),
    .acc      (acc)
  );

  csf_sqrt #(
    .OUT_W (LEN_W)
  ) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_go),
    .rad   (acc[SUM_W-1:0]),
    .busy  (sqrt_busy),
    .root  (len)
  );

  // quotient = (mag*2*step + L) / (2L): rounded mag*step/L, ties away
  csf_div #(
    .NUM_W (ACC_W),
    .DEN_W (DEN_W),
    .Q_W   (MAG_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .num   (acc),
    .den   ({len, 1'b0}),
    .busy  (div_busy),
    .quo   (quo)
  );

  // step selection on the fresh length
  assign len_c     = CMP_W'(len);
  assign max_c     = CMP_W'(max_step);
  assign crit_c    = CMP_W'(crit_step);
  assign len_zero  = (len == '0);
  assign in_mid    = (len_c > max_c) && (len_c < crit_c);
  assign over_crit = (len_c > crit_c);

  // signed difference at one extra bit, then magnitude and sign
  assign in_tgt[0] = in_ch.target_x;
  assign in_tgt[1] = in_ch.target_y;
  assign in_tgt[2] = in_ch.target_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_diff[i] = {in_tgt[i][POS_WIDTH-1], in_tgt[i]} -
                   {fol_r[i][POS_WIDTH-1], fol_r[i]};
    end
  end

  assign delta = neg_r[axis_r] ? (MAG_W'(0) - quo) : quo;

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= '0;
      ph_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      ph_r    <= ph_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    axis_nxt     = axis_r;
    ph_nxt       = ph_r;
    in_rdy       = 1'b0;
    acc_init     = 1'b0;
    acc_seed_len = 1'b0;
    mul_issue    = 1'b0;
    sq_mode      = 1'b0;
    sqrt_go      = 1'b0;
    div_go       = 1'b0;
    sel_go       = 1'b0;
    upd_go       = 1'b0;
    out_load     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_ch.valid) begin
          acc_init  = 1'b1;
          axis_nxt  = '0;
          ph_nxt    = 1'b0;
          state_nxt = ST_SQ;
        end
      end
      // low and high half of each axis square
      ST_SQ: begin
        sq_mode   = 1'b1;
        mul_issue = 1'b1;
        ph_nxt    = !ph_r;
        if (ph_r) begin
          if (axis_r == 2'd2) begin
            axis_nxt  = '0;
            state_nxt = ST_SQW;
          end else begin
            axis_nxt = axis_r + 2'd1;
          end
        end
      end
      ST_SQW: begin
        if (!mul_busy) begin
          sqrt_go   = 1'b1;
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (!sqrt_busy) begin
          state_nxt = ST_SEL;
        end
      end
      ST_SEL: begin
        sel_go = 1'b1;
        if (!len_zero && (in_mid || over_crit)) begin
          acc_init     = 1'b1;
          acc_seed_len = 1'b1;
          axis_nxt     = '0;
          ph_nxt       = 1'b0;
          state_nxt    = ST_MUL;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_MUL: begin
        mul_issue = 1'b1;
        ph_nxt    = !ph_r;
        if (ph_r) begin
          state_nxt = ST_MULW;
        end
      end
      ST_MULW: begin
        if (!mul_busy) begin
          div_go    = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        upd_go = 1'b1;
        if (axis_r == 2'd2) begin
          state_nxt = ST_DONE;
        end else begin
          acc_init     = 1'b1;
          acc_seed_len = 1'b1;
          axis_nxt     = axis_r + 2'd1;
          ph_nxt       = 1'b0;
          state_nxt    = ST_MUL;
        end
      end
      ST_DONE: begin
        if (!ovalid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ch.ready = in_rdy;

  // ---------------------------------------------------------------------
  // Item capture
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      for (int i = 0; i < 3; i++) begin
        tgt_r[i] <= in_tgt[i];
        neg_r[i] <= in_diff[i][MAG_W-1];
        mag_r[i] <= in_diff[i][MAG_W-1] ? (MAG_W'(0) - in_diff[i]) : in_diff[i];
      end
      trot_r[0] <= in_ch.target_rot_w;
      trot_r[1] <= in_ch.target_rot_x;
      trot_r[2] <= in_ch.target_rot_y;
      trot_r[3] <= in_ch.target_rot_z;
    end
    if (sel_go) begin
      step_r  <= in_mid ? max_step : crit_step;
      moved_r <= !len_zero;
    end
  end

  // ---------------------------------------------------------------------
  // Follower pose
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        fol_r[i] <= '0;
      end
      quat_r[0] <= ROT_ONE;
      quat_r[1] <= '0;
      quat_r[2] <= '0;
      quat_r[3] <= '0;
    end else begin
      if (sel_go && !len_zero) begin
        for (int i = 0; i < 4; i++) begin
          quat_r[i] <= trot_r[i];
        end
        // at or under max_step, or exactly at crit_step: land on the target
        if (!in_mid && !over_crit) begin
          for (int i = 0; i < 3; i++) begin
            fol_r[i] <= tgt_r[i];
          end
        end
      end
      if (upd_go) begin
        fol_r[axis_r] <= fol_r[axis_r] + delta[POS_WIDTH-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (out_load) begin
      ovalid_r <= 1'b1;
    end else if (out_ch.ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int i = 0; i < 3; i++) begin
        opos_r[i] <= fol_r[i];
      end
      for (int i = 0; i < 4; i++) begin
        orot_r[i] <= quat_r[i];
      end
      omoved_r <= moved_r;
    end
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.pos_x = opos_r[0];
  assign out_ch.pos_y = opos_r[1];
  assign out_ch.pos_z = opos_r[2];
  assign out_ch.rot_w = orot_r[0];
  assign out_ch.rot_x = orot_r[1];
  assign out_ch.rot_y = orot_r[2];
  assign out_ch.rot_z = orot_r[3];
  assign out_ch.moved = omoved_r;

endmodule

[rtl/core/csf_cfg.sv]
module csf_cfg import csf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready,
  output logic [STEP_W-1:0]     max_step,
  output logic [STEP_W-1:0]     crit_step
);

  logic [STEP_W-1:0] max_step_r;
  logic [STEP_W-1:0] crit_step_r;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_step_r  <= MAX_STEP_RST;
      crit_step_r <= CRIT_STEP_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_MAX_STEP:  max_step_r  <= pwdata[STEP_W-1:0];
        REG_CRIT_STEP: crit_step_r <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MAX_STEP:  prdata = DATA_W'(max_step_r);
      REG_CRIT_STEP: prdata = DATA_W'(crit_step_r);
      default:       prdata = '0;
    endcase
  end

  assign max_step  = max_step_r;
  assign crit_step = crit_step_r;

endmodule

[rtl/core/csf_mul.sv]
// Half-width multiply-accumulate: one a x b-chunk product per cycle,
// registered, then added into the accumulator the cycle after.
module csf_mul #(
  parameter int A_W   = 33,
  parameter int B_W   = 17,
  parameter int ACC_W = 66
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             init,
  input  logic [ACC_W-1:0] init_val,
  input  logic             issue,
  input  logic             hi,
  input  logic [A_W-1:0]   a,
  input  logic [B_W-1:0]   b,
  output logic             busy,
  output logic [ACC_W-1:0] acc
);

  logic [A_W+B_W-1:0] prod_r;
  logic               hi_r;
  logic               pend_r;
  logic [ACC_W-1:0]   acc_r;
  logic [ACC_W-1:0]   addend;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= a * b;
    hi_r   <= hi;
  end

  assign addend = hi_r ? (ACC_W'(prod_r) << B_W) : ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (init) begin
      acc_r <= init_val;
    end else if (pend_r) begin
      acc_r <= acc_r + addend;
    end
  end

  assign busy = pend_r;
  assign acc  = acc_r;

endmodule

[rtl/core/csf_sqrt.sv]
// Digit-by-digit integer square root, one result bit per cycle.
module csf_sqrt #(
  parameter int OUT_W = 33
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [2*OUT_W-1:0] rad,
  output logic               busy,
  output logic [OUT_W-1:0]   root
);

  localparam int IN_W  = 2 * OUT_W;
  localparam int CNT_W = $clog2(OUT_W + 1);

  logic [IN_W-1:0]  rad_r;
  logic [OUT_W+1:0] rem_r;
  logic [OUT_W-1:0] root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [OUT_W+2:0] rem_sh;
  logic [OUT_W+2:0] trial;
  logic [OUT_W+2:0] diff;
  logic             ge;

  assign rem_sh = {rem_r[OUT_W:0], rad_r[IN_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(OUT_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= ge ? diff[OUT_W+1:0] : rem_sh[OUT_W+1:0];
      root_r <= {root_r[OUT_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

[rtl/core/csf_div.sv]
// Restoring divider, one quotient bit per cycle. Caller guarantees
// num < den * 2^Q_W so the quotient fits Q_W bits.
module csf_div #(
  parameter int NUM_W = 66,
  parameter int DEN_W = 34,
  parameter int Q_W   = 33
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [Q_W-1:0]   quo
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [Q_W-1:0]   nq_r;   // numerator low bits out, quotient bits in
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [DEN_W:0]   sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign sh   = {rem_r, nq_r[Q_W-1]};
  assign ge   = sh >= {1'b0, den_r};
  assign diff = sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(Q_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= DEN_W'(num >> Q_W);
      nq_r  <= num[Q_W-1:0];
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
      nq_r  <= {nq_r[Q_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quo  = nq_r;

endmodule
